// ----- hw/rtl/deq_pkg.sv -----
// Shared types and constants for the double-ended queue unit.
// Used by the top level, the word store and the port checker; depends on nothing.
package deq_pkg;

   // Fixed field widths on the request and response ports.
   localparam int WORD_W   = 32;
   localparam int INDEX_W  = 4;
   localparam int MODE_W   = 3;
   localparam int COUNT_W  = 5;
   localparam int STATUS_W = 2;

   // Default sizing of the queue.
   localparam int DEPTH_DEFAULT      = 16;
   localparam int DATA_WIDTH_DEFAULT = 32;

   typedef enum logic [MODE_W-1:0] {
      MODE_PUSH_BACK  = 3'd0,
      MODE_PUSH_FRONT = 3'd1,
      MODE_POP_BACK   = 3'd2,
      MODE_POP_FRONT  = 3'd3,
      MODE_READ_AT    = 3'd4,
      MODE_WRITE_AT   = 3'd5
   } mode_type;

   typedef enum logic [STATUS_W-1:0] {
      ST_OK        = 2'd0,
      ST_OVERFLOW  = 2'd1,
      ST_UNDERFLOW = 2'd2,
      ST_BAD_INDEX = 2'd3
   } status_type;

   // Which response words are taken from the store's read data register
   // instead of from the value held alongside them.
   typedef struct packed {
      logic rd;
      logic front;
      logic back;
   } mem_sel_type;

endpackage

// ----- hw/rtl/deq_store.sv -----
// Word store of the double-ended queue: one write port, one read port
// with registered read data. Depends on deq_pkg for default sizes.
module deq_store #(
   parameter int DEPTH      = deq_pkg::DEPTH_DEFAULT,
   parameter int DATA_WIDTH = deq_pkg::DATA_WIDTH_DEFAULT
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [DATA_WIDTH-1:0]    wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [DATA_WIDTH-1:0]    rd_data
);

   logic [DATA_WIDTH-1:0] mem [DEPTH];
   logic [DATA_WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   // Read data holds until the next read so that it can be used later.
   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// ----- hw/rtl/double_ended_queue_unit.sv -----
// An accepted request word is held in stage A, then in the response register.
// Throughput: one request word per cycle unless a stalled response holds stage A; the store
// has one write and one read port and each request needs at most one of them.
// Reset (synchronous, active high) empties the queue and drops any words in flight;
// the store itself is not cleared, since only written entries are ever read.
// Depends on deq_pkg and deq_store.
module double_ended_queue_unit #(
   parameter int DEPTH      = deq_pkg::DEPTH_DEFAULT,
   parameter int DATA_WIDTH = deq_pkg::DATA_WIDTH_DEFAULT
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_valid,
   output logic                          req_stall,
   input  logic [deq_pkg::MODE_W-1:0]    req_mode,
   input  logic [deq_pkg::WORD_W-1:0]    req_value,
   input  logic [deq_pkg::INDEX_W-1:0]   req_index,
   output logic                          rsp_valid,
   input  logic                          rsp_stall,
   output logic [deq_pkg::WORD_W-1:0]    rsp_read_value,
   output logic [deq_pkg::WORD_W-1:0]    rsp_front_value,
   output logic [deq_pkg::WORD_W-1:0]    rsp_back_value,
   output logic [deq_pkg::COUNT_W-1:0]   rsp_count,
   output logic                          rsp_is_empty,
   output logic [deq_pkg::STATUS_W-1:0]  rsp_status
);

   // Ring pointer width, element count width, width of a logical position
   // (wide enough for both the count and the request index), and of a sum.
   localparam int AW = $clog2(DEPTH);
   localparam int CW = $clog2(DEPTH + 1);
   localparam int LW = (CW > deq_pkg::INDEX_W) ? CW : deq_pkg::INDEX_W;
   localparam int SW = LW + 1;

   // Ring slot of a logical position counted from the front. The position is
   // below DEPTH whenever the slot is used, so one conditional subtract wraps.
   function automatic logic [AW-1:0] slot_of(input logic [AW-1:0] head,
                                             input logic [LW-1:0] logical);
      logic [SW-1:0] sum;
      sum = SW'(head) + SW'(logical);
      if (sum >= SW'(DEPTH)) begin
         sum = sum - SW'(DEPTH);
      end
      return sum[AW-1:0];
   endfunction

   // Architectural state. The front and back words are cached in registers so
   // that a request needs at most one store read. After a pop, the new front
   // or back word is still on its way out of the store; the *_mem_ff flags
   // say that the store's read data register holds it.
   logic [AW-1:0]         head_ff, head_in;
   logic [CW-1:0]         count_ff, count_in;
   logic [DATA_WIDTH-1:0] front_ff, front_in;
   logic [DATA_WIDTH-1:0] back_ff, back_in;
   logic                  front_mem_ff, front_mem_in;
   logic                  back_mem_ff, back_mem_in;

   // Stage A: the accepted request's response, waiting for store read data.
   logic                        a_valid_ff, a_valid_in;
   logic [DATA_WIDTH-1:0]       a_rd_ff, a_rd_in;
   logic [DATA_WIDTH-1:0]       a_front_ff, a_front_in;
   logic [DATA_WIDTH-1:0]       a_back_ff, a_back_in;
   deq_pkg::mem_sel_type        a_sel_ff, a_sel_in;
   logic [CW-1:0]               a_count_ff;
   deq_pkg::status_type         a_status_ff, a_status_in;

   // Response register.
   logic                           rsp_valid_ff, rsp_valid_in;
   logic [deq_pkg::WORD_W-1:0]     rsp_rd_ff, rsp_rd_in;
   logic [deq_pkg::WORD_W-1:0]     rsp_front_ff, rsp_front_in;
   logic [deq_pkg::WORD_W-1:0]     rsp_back_ff, rsp_back_in;
   logic [deq_pkg::COUNT_W-1:0]    rsp_count_ff;
   logic                           rsp_empty_ff;
   deq_pkg::status_type            rsp_status_ff;

   // Store ports.
   logic                  wr_en;
   logic [AW-1:0]         wr_addr;
   logic                  rd_en;
   logic [AW-1:0]         rd_addr;
   logic [DATA_WIDTH-1:0] rd_data;

   // Request decode helpers.
   logic                  accept;
   logic                  a_move;
   logic [DATA_WIDTH-1:0] word;
   logic [DATA_WIDTH-1:0] front_cur;
   logic [DATA_WIDTH-1:0] back_cur;
   logic [LW-1:0]         idx_ext;
   logic [LW-1:0]         count_ext;
   logic                  is_full;
   logic                  is_none;
   logic                  idx_bad;
   logic                  two_or_more;

   // ----------------------------------------------------------------------
   // Handshake. Stage A drains into the response register whenever that
   // register is empty or its word is being taken, so a new request word is
   // accepted while stage A is empty or draining, even if a finished response waits downstream.
   // ----------------------------------------------------------------------
   assign a_move    = a_valid_ff && (!rsp_valid_ff || !rsp_stall);
   assign req_stall = a_valid_ff && !a_move;
   assign accept    = req_valid && !req_stall;

   // ----------------------------------------------------------------------
   // Single-pass request decode against the current state.
   // ----------------------------------------------------------------------
   assign word        = DATA_WIDTH'(req_value);
   assign front_cur   = front_mem_ff ? rd_data : front_ff;
   assign back_cur    = back_mem_ff ? rd_data : back_ff;
   assign idx_ext     = LW'(req_index);
   assign count_ext   = LW'(count_ff);
   assign is_full     = (count_ff == CW'(DEPTH));
   assign is_none     = (count_ff == '0);
   assign idx_bad     = (idx_ext >= count_ext);
   assign two_or_more = (count_ff > CW'(1));

   always_comb begin
      head_in      = head_ff;
      count_in     = count_ff;
      front_in     = front_cur;
      back_in      = back_cur;
      front_mem_in = 1'b0;
      back_mem_in  = 1'b0;
      wr_en        = 1'b0;
      wr_addr      = slot_of(head_ff, count_ext);
      rd_en        = 1'b0;
      rd_addr      = slot_of(head_ff, idx_ext);
      a_rd_in      = '0;
      a_sel_in     = '0;
      a_status_in  = deq_pkg::ST_OK;

      unique case (req_mode)
         deq_pkg::MODE_PUSH_BACK: begin
            if (is_full) begin
               a_status_in = deq_pkg::ST_OVERFLOW;
            end else begin
               wr_en    = accept;
               wr_addr  = slot_of(head_ff, count_ext);
               count_in = count_ff + CW'(1);
               back_in  = word;
               if (is_none) begin
                  front_in = word;
               end
            end
         end
         deq_pkg::MODE_PUSH_FRONT: begin
            if (is_full) begin
               a_status_in = deq_pkg::ST_OVERFLOW;
            end else begin
               head_in  = (head_ff == '0) ? AW'(DEPTH - 1) : head_ff - AW'(1);
               wr_en    = accept;
               wr_addr  = head_in;
               count_in = count_ff + CW'(1);
               front_in = word;
               if (is_none) begin
                  back_in = word;
               end
            end
         end
         deq_pkg::MODE_POP_BACK: begin
            if (is_none) begin
               a_status_in = deq_pkg::ST_UNDERFLOW;
            end else begin
               a_rd_in  = back_cur;
               count_in = count_ff - CW'(1);
               if (two_or_more) begin
                  // The new back word comes from the store.
                  rd_en       = accept;
                  rd_addr     = slot_of(head_ff, count_ext - LW'(2));
                  back_mem_in = 1'b1;
               end
            end
         end
         deq_pkg::MODE_POP_FRONT: begin
            if (is_none) begin
               a_status_in = deq_pkg::ST_UNDERFLOW;
            end else begin
               a_rd_in  = front_cur;
               head_in  = (head_ff == AW'(DEPTH - 1)) ? '0 : head_ff + AW'(1);
               count_in = count_ff - CW'(1);
               if (two_or_more) begin
                  rd_en        = accept;
                  rd_addr      = slot_of(head_ff, LW'(1));
                  front_mem_in = 1'b1;
               end
            end
         end
         deq_pkg::MODE_READ_AT: begin
            if (idx_bad) begin
               a_status_in = deq_pkg::ST_BAD_INDEX;
            end else begin
               rd_en       = accept;
               rd_addr     = slot_of(head_ff, idx_ext);
               a_sel_in.rd = 1'b1;
            end
         end
         deq_pkg::MODE_WRITE_AT: begin
            if (idx_bad) begin
               a_status_in = deq_pkg::ST_BAD_INDEX;
            end else begin
               wr_en   = accept;
               wr_addr = slot_of(head_ff, idx_ext);
               if (idx_ext == '0) begin
                  front_in = word;
               end
               if (idx_ext == count_ext - LW'(1)) begin
                  back_in = word;
               end
            end
         end
         default: begin
            // Unused modes leave the queue as it is.
         end
      endcase

      // Front and back words of the response reflect the state after the step.
      if (count_in == '0) begin
         a_front_in     = '0;
         a_back_in      = '0;
         a_sel_in.front = 1'b0;
         a_sel_in.back  = 1'b0;
      end else begin
         a_front_in     = front_in;
         a_back_in      = back_in;
         a_sel_in.front = front_mem_in;
         a_sel_in.back  = back_mem_in;
      end
   end

   deq_store #(
      .DEPTH      (DEPTH),
      .DATA_WIDTH (DATA_WIDTH)
   ) u_store (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (word),
      .rd_en   (rd_en),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   // ----------------------------------------------------------------------
   // State registers. The cached front and back words always take their
   // resolved value at an accept, so the pending flags only ever refer to
   // the most recent store read, which the store holds until the next one.
   // ----------------------------------------------------------------------
   always_ff @(posedge clock) begin
      if (reset) begin
         head_ff      <= '0;
         count_ff     <= '0;
         front_mem_ff <= 1'b0;
         back_mem_ff  <= 1'b0;
      end else if (accept) begin
         head_ff      <= head_in;
         count_ff     <= count_in;
         front_mem_ff <= front_mem_in;
         back_mem_ff  <= back_mem_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         front_ff <= front_in;
         back_ff  <= back_in;
      end
   end

   // ----------------------------------------------------------------------
   // Stage A. Its request is always the latest one accepted, so any store
   // read it needs is still sitting in the store's read data register when
   // it moves on.
   // ----------------------------------------------------------------------
   always_comb begin
      if (accept) begin
         a_valid_in = 1'b1;
      end else if (a_move) begin
         a_valid_in = 1'b0;
      end else begin
         a_valid_in = a_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         a_valid_ff <= 1'b0;
      end else begin
         a_valid_ff <= a_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         a_rd_ff     <= a_rd_in;
         a_front_ff  <= a_front_in;
         a_back_ff   <= a_back_in;
         a_sel_ff    <= a_sel_in;
         a_count_ff  <= count_in;
         a_status_ff <= a_status_in;
      end
   end

   // ----------------------------------------------------------------------
   // Response register.
   // ----------------------------------------------------------------------
   assign rsp_rd_in    = deq_pkg::WORD_W'(a_sel_ff.rd ? rd_data : a_rd_ff);
   assign rsp_front_in = deq_pkg::WORD_W'(a_sel_ff.front ? rd_data : a_front_ff);
   assign rsp_back_in  = deq_pkg::WORD_W'(a_sel_ff.back ? rd_data : a_back_ff);

   always_comb begin
      if (a_move) begin
         rsp_valid_in = 1'b1;
      end else begin
         rsp_valid_in = rsp_valid_ff && rsp_stall;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (a_move) begin
         rsp_rd_ff     <= rsp_rd_in;
         rsp_front_ff  <= rsp_front_in;
         rsp_back_ff   <= rsp_back_in;
         rsp_count_ff  <= deq_pkg::COUNT_W'(a_count_ff);
         rsp_empty_ff  <= (a_count_ff == '0);
         rsp_status_ff <= a_status_ff;
      end
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_read_value  = rsp_rd_ff;
   assign rsp_front_value = rsp_front_ff;
   assign rsp_back_value  = rsp_back_ff;
   assign rsp_count       = rsp_count_ff;
   assign rsp_is_empty    = rsp_empty_ff;
   assign rsp_status      = rsp_status_ff;

endmodule

// ----- hw/rtl/deq_checker.sv -----
// Port-level checks for the double-ended queue unit, attached by bind.
// Depends on deq_pkg and on the ports of double_ended_queue_unit.
module deq_checker #(
   parameter int DEPTH = deq_pkg::DEPTH_DEFAULT
) (
   input logic                          clock,
   input logic                          reset,
   input logic                          rsp_valid,
   input logic                          rsp_stall,
   input logic [deq_pkg::WORD_W-1:0]    rsp_read_value,
   input logic [deq_pkg::WORD_W-1:0]    rsp_front_value,
   input logic [deq_pkg::WORD_W-1:0]    rsp_back_value,
   input logic [deq_pkg::COUNT_W-1:0]   rsp_count,
   input logic                          rsp_is_empty,
   input logic [deq_pkg::STATUS_W-1:0]  rsp_status
);

   // A stalled response word stays in place.
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_read_value)
         && $stable(rsp_front_value) && $stable(rsp_back_value)
         && $stable(rsp_count) && $stable(rsp_status))
      else $error("response word changed while stalled");

   // An empty queue reports zero count and zero front and back words.
   a_empty_words: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_is_empty |->
         rsp_count == '0 && rsp_front_value == '0 && rsp_back_value == '0)
      else $error("empty flag disagrees with count or end words");

   // Overflow only happens on a full queue.
   a_overflow_full: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_status == deq_pkg::ST_OVERFLOW |->
         rsp_count == deq_pkg::COUNT_W'(DEPTH) && rsp_read_value == '0)
      else $error("overflow reported on a queue that is not full");

   // Underflow only happens on an empty queue and returns no word.
   a_underflow_empty: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_status == deq_pkg::ST_UNDERFLOW |->
         rsp_is_empty && rsp_read_value == '0)
      else $error("underflow reported on a queue that is not empty");

   // A rejected index returns no word.
   a_bad_index_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_status == deq_pkg::ST_BAD_INDEX |-> rsp_read_value == '0)
      else $error("bad index returned a word");

endmodule

bind double_ended_queue_unit deq_checker #(
   .DEPTH (DEPTH)
) u_deq_checker (
   .clock           (clock),
   .reset           (reset),
   .rsp_valid       (rsp_valid),
   .rsp_stall       (rsp_stall),
   .rsp_read_value  (rsp_read_value),
   .rsp_front_value (rsp_front_value),
   .rsp_back_value  (rsp_back_value),
   .rsp_count       (rsp_count),
   .rsp_is_empty    (rsp_is_empty),
   .rsp_status      (rsp_status)
);
